@@ src/sps_pkg.sv @@
package sps_pkg;

   // fixed field widths of the request, response and register port
   localparam int CMD_W        = 2;
   localparam int SLOT_FIELD_W = 4;
   localparam int DATA_FIELD_W = 32;
   localparam int ACTIVE_W     = 5;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

   // register index, taken from paddr[2] (byte address 4*i)
   localparam logic REG_ACTIVE_SLOTS = 1'b0;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD        = 2'd0,
      CMD_TAKE_INDEX = 2'd1,
      CMD_TAKE_LAST  = 2'd2
   } cmd_type;

endpackage

@@ src/slot_pool_store_unit.sv @@
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+--------------------------------
// request   | in        | req_valid / req_stall | req_cmd, req_slot_index, req_data_in
// response  | out       | rsp_valid / rsp_stall | rsp_ok, rsp_slot_used, rsp_data_out
// register  | in/out    | psel, penable, pready | paddr, pwdata, pwrite, prdata
//
// one command per cycle while req_stall is low; its response passes through the read stage and
// then the output register, the slot word coming out of the registered read port of the slot memory
// synchronous reset empties every slot and sets active_slots to 16; slot words are not cleared
// a stalled response sits in the output register while one more command is taken into
// the read stage; the request side stalls only when both are full and the output is held
module slot_pool_store_unit #(
   parameter int SLOTS     = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sps_pkg::CMD_W-1:0]          req_cmd,
   input  logic [sps_pkg::SLOT_FIELD_W-1:0]   req_slot_index,
   input  logic [sps_pkg::DATA_FIELD_W-1:0]   req_data_in,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_ok,
   output logic [sps_pkg::SLOT_FIELD_W-1:0]   rsp_slot_used,
   output logic [sps_pkg::DATA_FIELD_W-1:0]   rsp_data_out,

   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [sps_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [sps_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [sps_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   import sps_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   // common width for comparing slot numbers with the 4-bit index and 5-bit count
   localparam int SEL_W = (IDX_W + 1 > ACTIVE_W) ? IDX_W + 1 : ACTIVE_W;

   // register port
   logic [ACTIVE_W-1:0] active_ff;
   logic                csr_write;

   // pool state
   logic [SLOTS-1:0]    occ_ff;
   logic [SLOTS-1:0]    occ_in;

   // read stage: decision made, slot word on its way out of the memory
   logic                pipe_valid_ff;
   logic                pipe_ok_ff;
   logic                pipe_take_ff;
   logic [IDX_W-1:0]    pipe_slot_ff;

   // output register
   logic                     rsp_valid_ff;
   logic                     rsp_ok_ff;
   logic [SLOT_FIELD_W-1:0]  rsp_slot_ff;
   logic [DATA_FIELD_W-1:0]  rsp_data_ff;

   // handshake
   logic accept;
   logic out_free;
   logic pipe_move;

   // decode
   cmd_type          cmd;
   logic [SLOTS-1:0] live;
   logic [SLOTS-1:0] free_live;
   logic [SLOTS-1:0] occ_live;
   logic             add_hit;
   logic [IDX_W-1:0] add_slot;
   logic             last_hit;
   logic [IDX_W-1:0] last_slot;
   logic             idx_hit;
   logic [IDX_W-1:0] idx_slot;
   logic             dec_ok;
   logic             dec_take;
   logic [IDX_W-1:0] dec_slot;

   logic [WORD_BITS-1:0] ram_rd_data;

   // ---------------------------------------------------------------- register port
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready & (paddr[2] == REG_ACTIVE_SLOTS);
   assign prdata    = (paddr[2] == REG_ACTIVE_SLOTS) ? CSR_DATA_W'(active_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_write) begin
         active_ff <= pwdata[ACTIVE_W-1:0];
      end
   end

   // ---------------------------------------------------------------- handshake
   // output register frees up when empty or when its transfer completes
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign pipe_move = pipe_valid_ff & out_free;
   assign req_stall = pipe_valid_ff & ~out_free;
   assign accept    = req_valid & ~req_stall;

   // ---------------------------------------------------------------- command decode
   assign cmd = cmd_type'(req_cmd);

   always_comb begin
      // slots at or above the active count are out of play; a count above SLOTS leaves every slot live
      for (int s = 0; s < SLOTS; s++) begin
         live[s] = SEL_W'(s) < SEL_W'(active_ff);
      end
      free_live = ~occ_ff & live;
      occ_live  = occ_ff & live;
   end

   // lowest empty live slot
   always_comb begin
      add_hit  = |free_live;
      add_slot = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (free_live[s]) begin
            add_slot = IDX_W'(s);
         end
      end
   end

   // highest occupied live slot
   always_comb begin
      last_hit  = |occ_live;
      last_slot = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (occ_live[s]) begin
            last_slot = IDX_W'(s);
         end
      end
   end

   // named slot, only if live and occupied
   always_comb begin
      idx_hit  = 1'b0;
      idx_slot = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (SEL_W'(req_slot_index) == SEL_W'(s)) begin
            idx_hit  = occ_live[s];
            idx_slot = IDX_W'(s);
         end
      end
   end

   always_comb begin
      dec_ok   = 1'b0;
      dec_take = 1'b0;
      dec_slot = '0;
      unique case (cmd)
         CMD_ADD: begin
            dec_ok   = add_hit;
            dec_slot = add_slot;
         end
         CMD_TAKE_INDEX: begin
            dec_ok   = idx_hit;
            dec_take = idx_hit;
            dec_slot = idx_slot;
         end
         CMD_TAKE_LAST: begin
            dec_ok   = last_hit;
            dec_take = last_hit;
            dec_slot = last_slot;
         end
         default: begin
            // unused code: nothing changes, the response reports failure
            dec_ok = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------- occupied map
   always_comb begin
      occ_in = occ_ff;
      if (accept && dec_ok) begin
         occ_in[dec_slot] = ~dec_take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // ---------------------------------------------------------------- slot words
   // write on a successful add, read on a successful take; never both in one cycle
   sps_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (accept & dec_ok & ~dec_take),
      .wr_addr (dec_slot),
      .wr_data (WORD_BITS'(req_data_in)),
      .rd_en   (accept & dec_take),
      .rd_addr (dec_slot),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_valid_ff <= 1'b0;
      end else begin
         pipe_valid_ff <= accept | (pipe_valid_ff & ~pipe_move);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pipe_ok_ff   <= dec_ok;
         pipe_take_ff <= dec_take;
         pipe_slot_ff <= dec_slot;
      end
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pipe_move | (rsp_valid_ff & rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_move) begin
         rsp_ok_ff   <= pipe_ok_ff;
         // slot and data read as zero on failure
         rsp_slot_ff <= pipe_ok_ff ? SLOT_FIELD_W'(SEL_W'(pipe_slot_ff)) : '0;
         rsp_data_ff <= pipe_take_ff ? DATA_FIELD_W'(ram_rd_data) : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ok        = rsp_ok_ff;
   assign rsp_slot_used = rsp_slot_ff;
   assign rsp_data_out  = rsp_data_ff;

endmodule

@@ src/sps_ram.sv @@
module sps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
